>>> hw/rtl/tna_pkg.sv
package tna_pkg;

  localparam int VERTEX_DEPTH = 4096;
  localparam int COORD_BITS   = 16;
  localparam int INDEX_BITS   = 12;
  localparam int VERTEX_W     = 3 * COORD_BITS;

  // datapath widths
  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int MUL_W   = DIFF_W + 1;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int CROSS_W = 2 * DIFF_W + 1;
  localparam int MAG_W   = CROSS_W - 1;
  localparam int HALF_W  = MAG_W / 2;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int ROOT_W  = SUM_W / 2;
  localparam int QUO_W   = 31;
  localparam int NORM_W  = 16;
  localparam int AREA_W  = 36;
  localparam int CNT_W   = 6;

  localparam int S_ITERS   = SUM_W / 2;
  localparam int N_ITERS   = (QUO_W + 1) / 2;
  localparam int DIV_ITERS = QUO_W;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TRI  = 1'b1;

  typedef struct packed {
    logic                          opcode;
    logic        [INDEX_BITS-1:0]  vertex_index;
    logic signed [COORD_BITS-1:0]  coord_x;
    logic signed [COORD_BITS-1:0]  coord_y;
    logic signed [COORD_BITS-1:0]  coord_z;
    logic        [INDEX_BITS-1:0]  corner_a;
    logic        [INDEX_BITS-1:0]  corner_b;
    logic        [INDEX_BITS-1:0]  corner_c;
  } in_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] normal_x;
    logic signed [NORM_W-1:0] normal_y;
    logic signed [NORM_W-1:0] normal_z;
    logic        [AREA_W-1:0] area;
    logic                     degenerate;
  } out_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] z;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] x;
  } vtx_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] iters;
  } sqrt_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_CROSS,
    ST_ABS,
    ST_SQUARE,
    ST_SROOT,
    ST_SWAIT,
    ST_DLOAD,
    ST_DIV,
    ST_NROOT,
    ST_NWAIT,
    ST_DONE
  } state_t;

endpackage

>>> hw/rtl/tna_ram.sv
module tna_ram #(
  parameter int WIDTH = tna_pkg::VERTEX_W,
  parameter int DEPTH = tna_pkg::VERTEX_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/tna_isqrt.sv
module tna_isqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tna_pkg::sqrt_req_t            req,
  input  logic [tna_pkg::SUM_W-1:0]     operand,
  output logic                          done,
  output logic [tna_pkg::ROOT_W-1:0]    root
);

  localparam int REM_W = tna_pkg::ROOT_W + 3;

  logic [tna_pkg::SUM_W-1:0]  op_r, op_nxt;
  logic [REM_W-1:0]           rem_r, rem_nxt;
  logic [tna_pkg::ROOT_W-1:0] root_r, root_nxt;
  logic [tna_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [REM_W-1:0]           rem_sh;
  logic [REM_W-1:0]           trial;

  // one root bit per cycle, operand consumed two bits at a time from the top
  always_comb begin
    rem_sh   = {rem_r[REM_W-3:0], op_r[tna_pkg::SUM_W-1 -: 2]};
    trial    = {1'b0, root_r, 2'b01};
    op_nxt   = op_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      op_nxt   = operand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = req.iters;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      op_nxt = {op_r[tna_pkg::SUM_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[tna_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[tna_pkg::ROOT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == tna_pkg::CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    op_r   <= op_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

>>> hw/rtl/triangle_normal_and_area_top.sv
// Triangle face normal and area.
// Input channel (in_valid/in_ready/in_data): a load transaction (opcode 0) writes one
// vertex into the store and gives no result. A triangle transaction (opcode 1) reads
// corners a, b, c, forms the cross product (b - a) x (c - a), and gives a result: the
// unit normal in Q1.14, the area in squared coordinate units and a degenerate flag. A triangle
// passes through the store reads, the cross product and the squaring on one 18x18
// multiplier, the square root of the squared length, then per component a restoring
// division and a 16-step square root with their load and hand-off states, and last the
// output register. The divider and root unit are shared, so a new triangle is taken
// only after the last one has left its final state. A degenerate triangle ends after
// the squaring. in_ready is high only while no triangle is in work.
// Results sit in an output register until taken; loads and a new triangle are still
// taken while a result waits, but a finished triangle waits in its final state, with
// in_ready low, until the receiver frees the register.
// Reset (rst_n, synchronous) clears control only. The vertex store has no reset value;
// every vertex must be loaded before a triangle uses it.
module triangle_normal_and_area_top #(
  parameter int VERTEX_DEPTH = tna_pkg::VERTEX_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  tna_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output tna_pkg::out_t out_data
);

  localparam int ADDR_W = $clog2(VERTEX_DEPTH);

  tna_pkg::state_t state_r, state_nxt;

  logic [tna_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0] comp_r, comp_nxt;
  logic [1:0] part_r, part_nxt;
  logic       iss_done_r, iss_done_nxt;

  logic signed [tna_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic signed [tna_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic       prod_vld_r, prod_vld_nxt;
  logic [1:0] prod_comp_r, prod_comp_nxt;
  logic [1:0] prod_part_r, prod_part_nxt;

  logic [ADDR_W-1:0] ca_r, ca_nxt, cb_r, cb_nxt, cc_r, cc_nxt;
  tna_pkg::vtx_t p1_r, p1_nxt, p2_r, p2_nxt;

  logic [tna_pkg::DIFF_W-1:0]         u_r [3];
  logic [tna_pkg::DIFF_W-1:0]         u_nxt [3];
  logic [tna_pkg::DIFF_W-1:0]         v_r [3];
  logic [tna_pkg::DIFF_W-1:0]         v_nxt [3];
  logic signed [tna_pkg::CROSS_W-1:0] c_r [3];
  logic signed [tna_pkg::CROSS_W-1:0] c_nxt [3];
  logic                               sign_r [3];
  logic                               sign_nxt [3];
  logic [tna_pkg::MAG_W-1:0]          mag_r [3];
  logic [tna_pkg::MAG_W-1:0]          mag_nxt [3];
  logic [tna_pkg::SQ_W-1:0]           sq_r [3];
  logic [tna_pkg::SQ_W-1:0]           sq_nxt [3];
  logic [tna_pkg::NORM_W-1:0]         nrm_r [3];
  logic [tna_pkg::NORM_W-1:0]         nrm_nxt [3];

  logic [tna_pkg::SUM_W-1:0]  s_r, s_nxt;
  logic [tna_pkg::SUM_W-1:0]  term;
  logic [tna_pkg::SUM_W-1:0]  div_rem_r, div_rem_nxt;
  logic [tna_pkg::SUM_W-1:0]  div_sub;
  logic                       div_ge;
  logic [tna_pkg::QUO_W-1:0]  div_quo_r, div_quo_nxt;
  logic [tna_pkg::AREA_W-1:0] area_r, area_nxt;
  logic                       degen_r, degen_nxt;
  logic [tna_pkg::NORM_W:0]   q_sum;
  logic [tna_pkg::NORM_W-1:0] q_mag;

  logic          out_valid_r, out_valid_nxt;
  tna_pkg::out_t out_data_r, out_data_nxt;

  logic                        ram_we;
  logic [ADDR_W-1:0]           ram_waddr;
  logic [ADDR_W-1:0]           ram_raddr;
  logic [tna_pkg::VERTEX_W-1:0] ram_rdata;
  tna_pkg::vtx_t               rd_vtx;
  tna_pkg::vtx_t               wr_vtx;

  tna_pkg::sqrt_req_t           sq_req;
  logic [tna_pkg::SUM_W-1:0]    sq_operand;
  logic                         sq_done;
  logic [tna_pkg::ROOT_W-1:0]   sq_root;

  // slot index modulo the store depth, by compare and subtract of shifted depths
  function automatic logic [ADDR_W-1:0] idx_fold(input logic [tna_pkg::INDEX_BITS-1:0] raw);
    logic [31:0] v;
    v = 32'(raw);
    for (int k = 8; k >= 0; k--) begin
      if (v >= (32'(VERTEX_DEPTH) << k)) begin
        v = v - (32'(VERTEX_DEPTH) << k);
      end
    end
    return ADDR_W'(v);
  endfunction

  assign wr_vtx.x  = in_data.coord_x;
  assign wr_vtx.y  = in_data.coord_y;
  assign wr_vtx.z  = in_data.coord_z;
  assign ram_we    = in_valid && in_ready && (in_data.opcode == tna_pkg::OP_LOAD);
  assign ram_waddr = idx_fold(in_data.vertex_index);
  assign rd_vtx    = ram_rdata;

  tna_ram #(
    .WIDTH (tna_pkg::VERTEX_W),
    .DEPTH (VERTEX_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_vtx),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tna_isqrt u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (sq_req),
    .operand (sq_operand),
    .done    (sq_done),
    .root    (sq_root)
  );

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == tna_pkg::ST_CROSS) begin
      unique case ({comp_r, part_r[0]})
        3'b000: begin mul_a = {u_r[1][tna_pkg::DIFF_W-1], u_r[1]};
                      mul_b = {v_r[2][tna_pkg::DIFF_W-1], v_r[2]}; end
        3'b001: begin mul_a = {u_r[2][tna_pkg::DIFF_W-1], u_r[2]};
                      mul_b = {v_r[1][tna_pkg::DIFF_W-1], v_r[1]}; end
        3'b010: begin mul_a = {u_r[2][tna_pkg::DIFF_W-1], u_r[2]};
                      mul_b = {v_r[0][tna_pkg::DIFF_W-1], v_r[0]}; end
        3'b011: begin mul_a = {u_r[0][tna_pkg::DIFF_W-1], u_r[0]};
                      mul_b = {v_r[2][tna_pkg::DIFF_W-1], v_r[2]}; end
        3'b100: begin mul_a = {u_r[0][tna_pkg::DIFF_W-1], u_r[0]};
                      mul_b = {v_r[1][tna_pkg::DIFF_W-1], v_r[1]}; end
        3'b101: begin mul_a = {u_r[1][tna_pkg::DIFF_W-1], u_r[1]};
                      mul_b = {v_r[0][tna_pkg::DIFF_W-1], v_r[0]}; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else begin
      // square of a magnitude from its two halves
      unique case (part_r)
        2'd0: begin
          mul_a = {1'b0, mag_r[comp_r][tna_pkg::HALF_W-1:0]};
          mul_b = {1'b0, mag_r[comp_r][tna_pkg::HALF_W-1:0]};
        end
        2'd1: begin
          mul_a = {1'b0, mag_r[comp_r][tna_pkg::MAG_W-1:tna_pkg::HALF_W]};
          mul_b = {1'b0, mag_r[comp_r][tna_pkg::HALF_W-1:0]};
        end
        2'd2: begin
          mul_a = {1'b0, mag_r[comp_r][tna_pkg::MAG_W-1:tna_pkg::HALF_W]};
          mul_b = {1'b0, mag_r[comp_r][tna_pkg::MAG_W-1:tna_pkg::HALF_W]};
        end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  always_comb begin
    unique case (prod_part_r)
      2'd0:    term = {{(tna_pkg::SUM_W-tna_pkg::MAG_W){1'b0}}, prod_r[tna_pkg::MAG_W-1:0]};
      2'd1:    term = {{(tna_pkg::SUM_W-tna_pkg::MAG_W-tna_pkg::HALF_W-1){1'b0}},
                       prod_r[tna_pkg::MAG_W-1:0], {(tna_pkg::HALF_W+1){1'b0}}};
      2'd2:    term = {2'b00, prod_r[tna_pkg::MAG_W-1:0], {tna_pkg::MAG_W{1'b0}}};
      default: term = '0;
    endcase
  end

  assign div_ge  = div_rem_r >= s_r;
  assign div_sub = div_ge ? (div_rem_r - s_r) : div_rem_r;
  assign q_sum   = {1'b0, sq_root[tna_pkg::NORM_W-1:0]} + (tna_pkg::NORM_W+1)'(1);
  assign q_mag   = q_sum[tna_pkg::NORM_W:1];

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    comp_nxt      = comp_r;
    part_nxt      = part_r;
    iss_done_nxt  = iss_done_r;
    prod_nxt      = mul_a * mul_b;
    prod_vld_nxt  = 1'b0;
    prod_comp_nxt = comp_r;
    prod_part_nxt = part_r;
    ca_nxt        = ca_r;
    cb_nxt        = cb_r;
    cc_nxt        = cc_r;
    p1_nxt        = p1_r;
    p2_nxt        = p2_r;
    u_nxt         = u_r;
    v_nxt         = v_r;
    c_nxt         = c_r;
    sign_nxt      = sign_r;
    mag_nxt       = mag_r;
    sq_nxt        = sq_r;
    nrm_nxt       = nrm_r;
    s_nxt         = s_r;
    div_rem_nxt   = div_rem_r;
    div_quo_nxt   = div_quo_r;
    area_nxt      = area_r;
    degen_nxt     = degen_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    in_ready      = 1'b0;
    ram_raddr     = cc_r;
    sq_req.start  = 1'b0;
    sq_req.iters  = tna_pkg::CNT_W'(tna_pkg::S_ITERS);
    sq_operand    = s_r;

    // products are registered and land in the cycle after issue
    if (prod_vld_r) begin
      if (state_r == tna_pkg::ST_CROSS) begin
        if (prod_part_r == 2'd0) begin
          c_nxt[prod_comp_r] = tna_pkg::CROSS_W'(prod_r);
        end else begin
          c_nxt[prod_comp_r] = c_r[prod_comp_r] - tna_pkg::CROSS_W'(prod_r);
        end
      end else begin
        s_nxt               = s_r + term;
        sq_nxt[prod_comp_r] = sq_r[prod_comp_r] + term[tna_pkg::SQ_W-1:0];
      end
    end

    unique case (state_r)
      tna_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && in_data.opcode == tna_pkg::OP_TRI) begin
          ca_nxt    = idx_fold(in_data.corner_a);
          cb_nxt    = idx_fold(in_data.corner_b);
          cc_nxt    = idx_fold(in_data.corner_c);
          cnt_nxt   = '0;
          state_nxt = tna_pkg::ST_READ;
        end
      end
      tna_pkg::ST_READ: begin
        priority case (cnt_r)
          tna_pkg::CNT_W'(0): ram_raddr = ca_r;
          tna_pkg::CNT_W'(1): ram_raddr = cb_r;
          default:            ram_raddr = cc_r;
        endcase
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == tna_pkg::CNT_W'(1)) begin
          p1_nxt = rd_vtx;
        end
        if (cnt_r == tna_pkg::CNT_W'(2)) begin
          p2_nxt = rd_vtx;
        end
        if (cnt_r == tna_pkg::CNT_W'(3)) begin
          u_nxt[0] = {p2_r.x[tna_pkg::COORD_BITS-1], p2_r.x}
                   - {p1_r.x[tna_pkg::COORD_BITS-1], p1_r.x};
          u_nxt[1] = {p2_r.y[tna_pkg::COORD_BITS-1], p2_r.y}
                   - {p1_r.y[tna_pkg::COORD_BITS-1], p1_r.y};
          u_nxt[2] = {p2_r.z[tna_pkg::COORD_BITS-1], p2_r.z}
                   - {p1_r.z[tna_pkg::COORD_BITS-1], p1_r.z};
          v_nxt[0] = {rd_vtx.x[tna_pkg::COORD_BITS-1], rd_vtx.x}
                   - {p1_r.x[tna_pkg::COORD_BITS-1], p1_r.x};
          v_nxt[1] = {rd_vtx.y[tna_pkg::COORD_BITS-1], rd_vtx.y}
                   - {p1_r.y[tna_pkg::COORD_BITS-1], p1_r.y};
          v_nxt[2] = {rd_vtx.z[tna_pkg::COORD_BITS-1], rd_vtx.z}
                   - {p1_r.z[tna_pkg::COORD_BITS-1], p1_r.z};
          comp_nxt     = '0;
          part_nxt     = '0;
          iss_done_nxt = 1'b0;
          state_nxt    = tna_pkg::ST_CROSS;
        end
      end
      tna_pkg::ST_CROSS, tna_pkg::ST_SQUARE: begin
        if (!iss_done_r) begin
          prod_vld_nxt = 1'b1;
          if ((state_r == tna_pkg::ST_CROSS && part_r == 2'd1) ||
              (state_r == tna_pkg::ST_SQUARE && part_r == 2'd2)) begin
            part_nxt = '0;
            if (comp_r == 2'd2) begin
              comp_nxt     = '0;
              iss_done_nxt = 1'b1;
            end else begin
              comp_nxt = comp_r + 1'b1;
            end
          end else begin
            part_nxt = part_r + 1'b1;
          end
        end else begin
          // drain cycle: last product accumulates now
          iss_done_nxt = 1'b0;
          state_nxt    = (state_r == tna_pkg::ST_CROSS) ? tna_pkg::ST_ABS : tna_pkg::ST_SROOT;
        end
      end
      tna_pkg::ST_ABS: begin
        for (int i = 0; i < 3; i++) begin
          sign_nxt[i] = c_r[i][tna_pkg::CROSS_W-1];
          mag_nxt[i]  = c_r[i][tna_pkg::CROSS_W-1] ? tna_pkg::MAG_W'(-c_r[i])
                                                   : tna_pkg::MAG_W'(c_r[i]);
          sq_nxt[i]   = '0;
        end
        s_nxt     = '0;
        state_nxt = tna_pkg::ST_SQUARE;
      end
      tna_pkg::ST_SROOT: begin
        if (s_r == '0) begin
          degen_nxt = 1'b1;
          area_nxt  = '0;
          for (int i = 0; i < 3; i++) begin
            nrm_nxt[i] = '0;
          end
          state_nxt = tna_pkg::ST_DONE;
        end else begin
          degen_nxt    = 1'b0;
          sq_req.start = 1'b1;
          state_nxt    = tna_pkg::ST_SWAIT;
        end
      end
      tna_pkg::ST_SWAIT: begin
        if (sq_done) begin
          area_nxt  = tna_pkg::AREA_W'(({1'b0, sq_root} + (tna_pkg::ROOT_W+1)'(1)) >> 1);
          comp_nxt  = '0;
          state_nxt = tna_pkg::ST_DLOAD;
        end
      end
      tna_pkg::ST_DLOAD: begin
        div_rem_nxt = {2'b00, sq_r[comp_r]};
        div_quo_nxt = '0;
        cnt_nxt     = '0;
        state_nxt   = tna_pkg::ST_DIV;
      end
      tna_pkg::ST_DIV: begin
        // quotient of |c|^2 * 2^30 by the squared length
        div_rem_nxt = {div_sub[tna_pkg::SUM_W-2:0], 1'b0};
        div_quo_nxt = {div_quo_r[tna_pkg::QUO_W-2:0], div_ge};
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == tna_pkg::CNT_W'(tna_pkg::DIV_ITERS - 1)) begin
          state_nxt = tna_pkg::ST_NROOT;
        end
      end
      tna_pkg::ST_NROOT: begin
        sq_req.start = 1'b1;
        sq_req.iters = tna_pkg::CNT_W'(tna_pkg::N_ITERS);
        sq_operand   = {1'b0, div_quo_r,
                        {(tna_pkg::SUM_W - tna_pkg::QUO_W - 1){1'b0}}};
        state_nxt    = tna_pkg::ST_NWAIT;
      end
      tna_pkg::ST_NWAIT: begin
        sq_req.iters = tna_pkg::CNT_W'(tna_pkg::N_ITERS);
        sq_operand   = {1'b0, div_quo_r,
                        {(tna_pkg::SUM_W - tna_pkg::QUO_W - 1){1'b0}}};
        if (sq_done) begin
          // normal magnitude is (root + 1) / 2 truncated: half the root, rounded half up
          nrm_nxt[comp_r] = sign_r[comp_r] ? -q_mag : q_mag;
          if (comp_r == 2'd2) begin
            state_nxt = tna_pkg::ST_DONE;
          end else begin
            comp_nxt  = comp_r + 1'b1;
            state_nxt = tna_pkg::ST_DLOAD;
          end
        end
      end
      tna_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt.normal_x   = nrm_r[0];
          out_data_nxt.normal_y   = nrm_r[1];
          out_data_nxt.normal_z   = nrm_r[2];
          out_data_nxt.area       = area_r;
          out_data_nxt.degenerate = degen_r;
          out_valid_nxt           = 1'b1;
          state_nxt               = tna_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tna_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tna_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      prod_vld_r  <= 1'b0;
      iss_done_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      prod_vld_r  <= prod_vld_nxt;
      iss_done_r  <= iss_done_nxt;
    end
    cnt_r       <= cnt_nxt;
    comp_r      <= comp_nxt;
    part_r      <= part_nxt;
    prod_r      <= prod_nxt;
    prod_comp_r <= prod_comp_nxt;
    prod_part_r <= prod_part_nxt;
    ca_r        <= ca_nxt;
    cb_r        <= cb_nxt;
    cc_r        <= cc_nxt;
    p1_r        <= p1_nxt;
    p2_r        <= p2_nxt;
    u_r         <= u_nxt;
    v_r         <= v_nxt;
    c_r         <= c_nxt;
    sign_r      <= sign_nxt;
    mag_r       <= mag_nxt;
    sq_r        <= sq_nxt;
    nrm_r       <= nrm_nxt;
    s_r         <= s_nxt;
    div_rem_r   <= div_rem_nxt;
    div_quo_r   <= div_quo_nxt;
    area_r      <= area_nxt;
    degen_r     <= degen_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
